/* rtl/spce_pkg.sv */
// ----------------------------------------------------------------------------
// Sphere pair contact engine package
// Shared request, result and table entry types, and fixed field widths.
// ----------------------------------------------------------------------------
package spce_pkg;

    localparam int COORD_W = 24;
    localparam int RAD_W   = 20;
    localparam int LINK_W  = 8;
    localparam int IDX_W   = 8;
    localparam int DEPTH_W = 21;
    localparam int NORM_W  = 16;
    localparam int DIFF_W  = 25;
    localparam int DSQ_W   = 50;
    localparam int ROOT_W  = 25;
    localparam int NUM_W   = 46;
    localparam int DEN_W   = 26;
    localparam int QUO_W   = 25;
    localparam int PROD_W  = 50;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [IDX_W-1:0]          first_sphere;
        logic [IDX_W-1:0]          second_sphere;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [RAD_W-1:0]          sphere_size;
        logic [LINK_W-1:0]         owner_link;
    } request_t;

    typedef struct packed {
        logic                      collided;
        logic [LINK_W-1:0]         link_a;
        logic [LINK_W-1:0]         link_b;
        logic [DEPTH_W-1:0]        depth;
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [NORM_W-1:0]  normal_z;
        logic signed [COORD_W-1:0] contact_x;
        logic signed [COORD_W-1:0] contact_y;
        logic signed [COORD_W-1:0] contact_z;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] center_z;
        logic [RAD_W-1:0]   radius;
        logic [LINK_W-1:0]  link;
    } entry_t;

endpackage

/* rtl/spce_table.sv */
// ----------------------------------------------------------------------------
// Sphere table
// Single write port, single registered read port memory of sphere entries.
// ----------------------------------------------------------------------------
module spce_table #(
    parameter int DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  spce_pkg::entry_t              wr_data,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output spce_pkg::entry_t              rd_data
);

    spce_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/spce_sqrt.sv */
// ----------------------------------------------------------------------------
// Square root unit
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module spce_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [spce_pkg::DSQ_W-1:0]    value,
    output logic                          done,
    output logic [spce_pkg::ROOT_W-1:0]   root,
    output logic [spce_pkg::ROOT_W+1:0]   rem
);

    localparam int RW = spce_pkg::ROOT_W;

    logic [spce_pkg::DSQ_W-1:0] val_reg;
    logic [RW+1:0]              rem_reg;
    logic [RW-1:0]              root_reg;
    logic [4:0]                 cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [RW+3:0]              rem_sh;
    logic [RW+3:0]              trial;
    logic                       ge;

    always_comb
    begin
        rem_sh = {rem_reg, val_reg[spce_pkg::DSQ_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(RW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            val_reg  <= {val_reg[spce_pkg::DSQ_W-3:0], 2'b00};
            rem_reg  <= ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/spce_div.sv */
// ----------------------------------------------------------------------------
// Divider unit
// Restoring division, one quotient bit per cycle, for quotients below 2^25.
// ----------------------------------------------------------------------------
module spce_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [spce_pkg::NUM_W-1:0]    num,
    input  logic [spce_pkg::DEN_W-1:0]    den,
    output logic                          done,
    output logic [spce_pkg::QUO_W-1:0]    quo
);

    localparam int QW = spce_pkg::QUO_W;
    localparam int DW = spce_pkg::DEN_W;

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] lo_reg;
    logic [4:0]    cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;
    logic          ge;

    always_comb
    begin
        rem_sh = {rem_reg, lo_reg[QW-1]};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(QW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DW'(num[spce_pkg::NUM_W-1:QW]);
            lo_reg  <= num[QW-1:0];
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);
            lo_reg  <= {lo_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = lo_reg;

endmodule

/* rtl/sphere_pair_contact_engine.sv */
// ----------------------------------------------------------------------------
// Sphere pair contact engine
// A load request writes one table entry if its index and link are in range. A
// check request reads both entries, squares the center differences and the
// radius sum on one shared multiplier, and, when the spheres meet, runs a
// bit-serial square root and six bit-serial divisions for the normal and the
// contact point. A check that misses, or whose centers coincide, skips the
// square root and the divisions; a colliding check with distinct centers runs
// the 25-step square root and the six 25-step divisions on the one divider.
// The block takes no new request while a check is in progress.
// ----------------------------------------------------------------------------
module sphere_pair_contact_engine #(
    parameter int SPHERE_COUNT = 256,
    parameter int LINK_COUNT   = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 request_valid,
    output logic                 request_stall,
    input  spce_pkg::request_t   request,
    output logic                 result_valid,
    input  logic                 result_stall,
    output spce_pkg::result_t    result
);

    localparam int MEM_DEPTH = (SPHERE_COUNT < 256) ? SPHERE_COUNT : 256;
    localparam int AW        = $clog2(MEM_DEPTH);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_RD_A   = 11'b00000000010,
        ST_RD_B   = 11'b00000000100,
        ST_DIFF   = 11'b00000001000,
        ST_MUL    = 11'b00000010000,
        ST_CMP    = 11'b00000100000,
        ST_SQRT   = 11'b00001000000,
        ST_DMUL   = 11'b00010000000,
        ST_DSTART = 11'b00100000000,
        ST_DWAIT  = 11'b01000000000,
        ST_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]                      mul_cnt_reg;
    logic [2:0]                      axis_reg;
    logic                            res_valid_reg;
    spce_pkg::result_t               res_reg;
    spce_pkg::result_t               work_reg;

    logic [AW-1:0]                   idx_a_reg, idx_b_reg;
    logic [spce_pkg::COORD_W-1:0]    ca_reg   [3];
    logic [spce_pkg::DIFF_W-1:0]     mag_reg  [3];
    logic                            neg_reg  [3];
    logic [spce_pkg::RAD_W-1:0]      ra_reg;
    logic [spce_pkg::DEPTH_W-1:0]    r_reg;
    logic [spce_pkg::LINK_W-1:0]     link_a_reg;
    logic [spce_pkg::DSQ_W-1:0]      dsq_reg;
    logic [spce_pkg::DEN_W-1:0]      dist_reg;
    logic [spce_pkg::PROD_W-1:0]     prod_reg;

    logic                            accept;
    logic                            a_ok, b_ok, link_ok;
    logic                            out_free;
    logic                            wr_en;
    spce_pkg::entry_t                wr_data;
    spce_pkg::entry_t                rd_data;
    logic [AW-1:0]                   rd_addr;
    logic [spce_pkg::COORD_W-1:0]    cb       [3];
    logic [spce_pkg::DIFF_W-1:0]     dk       [3];
    logic [spce_pkg::DIFF_W-1:0]     mul_a, mul_b;
    logic [1:0]                      ax;
    logic                            sq_start, sq_done;
    logic [spce_pkg::ROOT_W-1:0]     sq_root;
    logic [spce_pkg::ROOT_W+1:0]     sq_rem;
    logic [spce_pkg::DEN_W-1:0]      dist_calc;
    logic                            dv_start, dv_done;
    logic [spce_pkg::NUM_W-1:0]      dv_num;
    logic [spce_pkg::DEN_W-1:0]      dv_den;
    logic [spce_pkg::QUO_W-1:0]      dv_quo;
    logic [spce_pkg::NORM_W-1:0]     norm_val;
    logic [spce_pkg::DIFF_W-1:0]     signed_q;
    logic [spce_pkg::DIFF_W-1:0]     contact_sum;

    assign request_stall = (state_reg != ST_IDLE);
    assign accept        = request_valid && !request_stall;
    assign a_ok    = ({24'd0, request.first_sphere} < 32'(SPHERE_COUNT));
    assign b_ok    = ({24'd0, request.second_sphere} < 32'(SPHERE_COUNT));
    assign link_ok = ({24'd0, request.owner_link} < 32'(LINK_COUNT));
    assign out_free = !res_valid_reg || !result_stall;

    assign wr_en = accept && (request.action == spce_pkg::ACT_LOAD) && a_ok && link_ok;
    assign wr_data.center_x = request.pos_x;
    assign wr_data.center_y = request.pos_y;
    assign wr_data.center_z = request.pos_z;
    assign wr_data.radius   = request.sphere_size;
    assign wr_data.link     = request.owner_link;
    assign rd_addr = (state_reg == ST_RD_A) ? idx_a_reg : idx_b_reg;

    spce_table #(
        .DEPTH (MEM_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (request.first_sphere[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        cb[0] = rd_data.center_x;
        cb[1] = rd_data.center_y;
        cb[2] = rd_data.center_z;
        for (int k = 0; k < 3; k++)
        begin
            dk[k] = {cb[k][spce_pkg::COORD_W-1], cb[k]}
                  - {ca_reg[k][spce_pkg::COORD_W-1], ca_reg[k]};
        end
    end

    assign ax = (axis_reg < 3'd3) ? axis_reg[1:0] : 2'(axis_reg - 3'd3);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL:
            begin
                case (mul_cnt_reg)
                    2'd0:
                    begin
                        mul_a = mag_reg[0];
                        mul_b = mag_reg[0];
                    end
                    2'd1:
                    begin
                        mul_a = mag_reg[1];
                        mul_b = mag_reg[1];
                    end
                    2'd2:
                    begin
                        mul_a = mag_reg[2];
                        mul_b = mag_reg[2];
                    end
                    default:
                    begin
                        mul_a = spce_pkg::DIFF_W'(r_reg);
                        mul_b = spce_pkg::DIFF_W'(r_reg);
                    end
                endcase
            end
            ST_DMUL:
            begin
                mul_a = mag_reg[ax];
                mul_b = (axis_reg < 3'd3) ? spce_pkg::DIFF_W'(32768)
                                          : spce_pkg::DIFF_W'(ra_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sq_start  = (state_reg == ST_CMP) && (dsq_reg <= prod_reg) && (dsq_reg != '0);
    assign dist_calc = spce_pkg::DEN_W'(sq_root)
                     + spce_pkg::DEN_W'(sq_rem > {2'b00, sq_root});

    spce_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (dsq_reg),
        .done  (sq_done),
        .root  (sq_root),
        .rem   (sq_rem)
    );

    assign dv_start = (state_reg == ST_DSTART);
    assign dv_num   = (axis_reg < 3'd3)
                    ? spce_pkg::NUM_W'(prod_reg) + spce_pkg::NUM_W'(dist_reg >> 1)
                    : spce_pkg::NUM_W'(prod_reg) + spce_pkg::NUM_W'(r_reg >> 1);
    assign dv_den   = (axis_reg < 3'd3) ? dist_reg : spce_pkg::DEN_W'(r_reg);

    spce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    always_comb
    begin
        if (!neg_reg[ax] && dv_quo[15])
        begin
            norm_val = 16'h7FFF;
        end
        else if (neg_reg[ax])
        begin
            norm_val = ~dv_quo[15:0] + 16'd1;
        end
        else
        begin
            norm_val = dv_quo[15:0];
        end
        signed_q    = neg_reg[ax] ? (~dv_quo + 25'd1) : dv_quo;
        contact_sum = {ca_reg[ax][spce_pkg::COORD_W-1], ca_reg[ax]} + signed_q;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (request.action == spce_pkg::ACT_CHECK))
                begin
                    state_next = (a_ok && b_ok) ? ST_RD_A : ST_DONE;
                end
            end
            ST_RD_A:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MUL;
            ST_MUL:
            begin
                if (mul_cnt_reg == 2'd3)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:    state_next = sq_start ? ST_SQRT : ST_DONE;
            ST_SQRT:
            begin
                if (sq_done)
                begin
                    state_next = ST_DMUL;
                end
            end
            ST_DMUL:   state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:
            begin
                if (dv_done)
                begin
                    state_next = (axis_reg == 3'd5) ? ST_DONE : ST_DMUL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_cnt_reg   <= '0;
            axis_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL)
            begin
                mul_cnt_reg <= mul_cnt_reg + 2'd1;
            end
            else
            begin
                mul_cnt_reg <= '0;
            end
            if (state_reg == ST_SQRT)
            begin
                axis_reg <= '0;
            end
            else if ((state_reg == ST_DWAIT) && dv_done)
            begin
                axis_reg <= axis_reg + 3'd1;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= spce_pkg::PROD_W'(mul_a * mul_b);
        if (accept)
        begin
            idx_a_reg <= request.first_sphere[AW-1:0];
            idx_b_reg <= request.second_sphere[AW-1:0];
            work_reg  <= '0;
        end
        case (state_reg)
            ST_RD_B:
            begin
                ca_reg[0]  <= rd_data.center_x;
                ca_reg[1]  <= rd_data.center_y;
                ca_reg[2]  <= rd_data.center_z;
                ra_reg     <= rd_data.radius;
                link_a_reg <= rd_data.link;
            end
            ST_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_reg[k] <= dk[k][spce_pkg::DIFF_W-1];
                    mag_reg[k] <= dk[k][spce_pkg::DIFF_W-1] ? (~dk[k] + 25'd1) : dk[k];
                end
                r_reg           <= {1'b0, ra_reg} + {1'b0, rd_data.radius};
                work_reg.link_b <= rd_data.link;
                dsq_reg         <= '0;
            end
            ST_MUL:
            begin
                if (mul_cnt_reg != 2'd0)
                begin
                    dsq_reg <= dsq_reg + prod_reg;
                end
            end
            ST_CMP:
            begin
                if (dsq_reg <= prod_reg)
                begin
                    work_reg.collided <= 1'b1;
                    work_reg.link_a   <= link_a_reg;
                    if (dsq_reg == '0)
                    begin
                        work_reg.depth     <= r_reg;
                        work_reg.contact_x <= ca_reg[0];
                        work_reg.contact_y <= ca_reg[1];
                        work_reg.contact_z <= ca_reg[2];
                    end
                end
                else
                begin
                    work_reg.link_b <= '0;
                end
            end
            ST_SQRT:
            begin
                if (sq_done)
                begin
                    dist_reg       <= dist_calc;
                    work_reg.depth <= spce_pkg::DEPTH_W'(r_reg - spce_pkg::DEPTH_W'(dist_calc));
                end
            end
            ST_DWAIT:
            begin
                if (dv_done)
                begin
                    case (axis_reg)
                        3'd0:    work_reg.normal_x  <= norm_val;
                        3'd1:    work_reg.normal_y  <= norm_val;
                        3'd2:    work_reg.normal_z  <= norm_val;
                        3'd3:    work_reg.contact_x <= contact_sum[spce_pkg::COORD_W-1:0];
                        3'd4:    work_reg.contact_y <= contact_sum[spce_pkg::COORD_W-1:0];
                        default: work_reg.contact_z <= contact_sum[spce_pkg::COORD_W-1:0];
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        if ((state_reg == ST_DONE) && out_free)
        begin
            res_reg <= work_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.action == spce_pkg::ACT_CHECK)) |=> request_stall)
        else $error("check request did not start the sequencer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.collided) |->
            (result.depth == '0 && result.link_a == '0 && result.link_b == '0))
        else $error("miss result carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the completion state");

endmodule

/* sim/sphere_pair_contact_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere pair contact engine testbench
// Loads sphere entries and checks pairs against them, predicting each contact
// result with a behavioral copy of the sphere table and integer arithmetic.
// Results are compared field by field in order. Both sides stall at random.
// ----------------------------------------------------------------------------
module sphere_pair_contact_engine_tb;

    localparam int  SPHERES     = 256;
    localparam int  CYCLE_LIMIT = 2000000;

    logic               clk;
    logic               rst_n;
    logic               request_valid;
    logic               request_stall;
    spce_pkg::request_t request;
    logic               result_valid;
    logic               result_stall;
    spce_pkg::result_t  result;

    logic signed [spce_pkg::COORD_W-1:0] center_x_mem [SPHERES];
    logic signed [spce_pkg::COORD_W-1:0] center_y_mem [SPHERES];
    logic signed [spce_pkg::COORD_W-1:0] center_z_mem [SPHERES];
    logic [spce_pkg::RAD_W-1:0]          radius_mem   [SPHERES];
    logic [spce_pkg::LINK_W-1:0]         link_mem     [SPHERES];
    bit                                  loaded       [SPHERES];
    int                                  recent_loads [$];

    spce_pkg::result_t pending_contacts [$];
    int                mismatch_count;
    int                cycle_count;
    bit                idle_enable;
    int                result_stall_left;

    logic signed [spce_pkg::COORD_W-1:0] cluster_x, cluster_y, cluster_z;

    sphere_pair_contact_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .request       (request),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic longint unsigned root_of(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint ratio_round(longint num, longint unsigned mul,
                                           longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q   = (mag * mul + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic spce_pkg::result_t contact_of(int a, int b);
        spce_pkg::result_t r;
        longint            ca [3];
        longint            d  [3];
        longint unsigned   ra, rsum, dsq, root_dist, mag;
        longint            n, c;
        r     = '0;
        ca[0] = center_x_mem[a];
        ca[1] = center_y_mem[a];
        ca[2] = center_z_mem[a];
        d[0]  = longint'(center_x_mem[b]) - ca[0];
        d[1]  = longint'(center_y_mem[b]) - ca[1];
        d[2]  = longint'(center_z_mem[b]) - ca[2];
        ra    = radius_mem[a];
        rsum  = ra + radius_mem[b];
        dsq   = 0;
        for (int k = 0; k < 3; k++)
        begin
            mag  = (d[k] < 0) ? longint'(-d[k]) : longint'(d[k]);
            dsq += mag * mag;
        end
        if (dsq > rsum * rsum)
            return r;
        r.collided = 1'b1;
        r.link_a   = link_mem[a];
        r.link_b   = link_mem[b];
        if (dsq == 0)
        begin
            r.depth     = rsum[spce_pkg::DEPTH_W-1:0];
            r.contact_x = center_x_mem[a];
            r.contact_y = center_y_mem[a];
            r.contact_z = center_z_mem[a];
            return r;
        end
        root_dist = root_of(dsq);
        if (dsq - root_dist * root_dist > root_dist)
            root_dist++;
        r.depth = spce_pkg::DEPTH_W'(rsum - root_dist);
        for (int k = 0; k < 3; k++)
        begin
            n = ratio_round(d[k], 32768, root_dist);
            c = ca[k] + ratio_round(d[k], ra, rsum);
            if (n > 32767)
                n = 32767;
            if (n < -32768)
                n = -32768;
            case (k)
                0:
                begin
                    r.normal_x  = spce_pkg::NORM_W'(n);
                    r.contact_x = spce_pkg::COORD_W'(c);
                end
                1:
                begin
                    r.normal_y  = spce_pkg::NORM_W'(n);
                    r.contact_y = spce_pkg::COORD_W'(c);
                end
                default:
                begin
                    r.normal_z  = spce_pkg::NORM_W'(n);
                    r.contact_z = spce_pkg::COORD_W'(c);
                end
            endcase
        end
        return r;
    endfunction

    task automatic apply_request(spce_pkg::request_t req);
        if (req.action == spce_pkg::ACT_LOAD)
        begin
            center_x_mem[req.first_sphere] = req.pos_x;
            center_y_mem[req.first_sphere] = req.pos_y;
            center_z_mem[req.first_sphere] = req.pos_z;
            radius_mem[req.first_sphere]   = req.sphere_size;
            link_mem[req.first_sphere]     = req.owner_link;
        end
        else
            pending_contacts = {pending_contacts,
                contact_of(int'(req.first_sphere), int'(req.second_sphere))};
    endtask

    task automatic send_request(spce_pkg::request_t req);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            request_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        request_valid <= 1'b1;
        request       <= req;
        do
            @(posedge clk);
        while (request_stall);
        apply_request(req);
    endtask

    initial
    begin
        result_stall      = 1'b0;
        result_stall_left = 0;
        mismatch_count    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                check_result(result);
            if (result_stall_left > 0)
            begin
                result_stall_left--;
                result_stall <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                result_stall_left = $urandom_range(0, 5);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    task automatic check_result(spce_pkg::result_t got);
        spce_pkg::result_t want;
        if (pending_contacts.size() == 0)
        begin
            $display("%0t: result with none expected: %h", $time, got);
            mismatch_count++;
            return;
        end
        want = pending_contacts.pop_front();
        if (got.collided !== want.collided)
            $display("%0t: collided exp %0d got %0d", $time, want.collided, got.collided);
        if (got.link_a !== want.link_a)
            $display("%0t: link_a exp %0d got %0d", $time, want.link_a, got.link_a);
        if (got.link_b !== want.link_b)
            $display("%0t: link_b exp %0d got %0d", $time, want.link_b, got.link_b);
        if (got.depth !== want.depth)
            $display("%0t: depth exp %0d got %0d", $time, want.depth, got.depth);
        if (got.normal_x !== want.normal_x)
            $display("%0t: normal_x exp %0d got %0d", $time, want.normal_x, got.normal_x);
        if (got.normal_y !== want.normal_y)
            $display("%0t: normal_y exp %0d got %0d", $time, want.normal_y, got.normal_y);
        if (got.normal_z !== want.normal_z)
            $display("%0t: normal_z exp %0d got %0d", $time, want.normal_z, got.normal_z);
        if (got.contact_x !== want.contact_x)
            $display("%0t: contact_x exp %0d got %0d", $time, want.contact_x, got.contact_x);
        if (got.contact_y !== want.contact_y)
            $display("%0t: contact_y exp %0d got %0d", $time, want.contact_y, got.contact_y);
        if (got.contact_z !== want.contact_z)
            $display("%0t: contact_z exp %0d got %0d", $time, want.contact_z, got.contact_z);
        if (got !== want)
            mismatch_count++;
    endtask

    task automatic load_sphere(int idx, int x, int y, int z, int rad, int link);
        spce_pkg::request_t req;
        req               = '0;
        req.action        = spce_pkg::ACT_LOAD;
        req.first_sphere  = spce_pkg::IDX_W'(idx);
        req.second_sphere = spce_pkg::IDX_W'($urandom);
        req.pos_x         = spce_pkg::COORD_W'(x);
        req.pos_y         = spce_pkg::COORD_W'(y);
        req.pos_z         = spce_pkg::COORD_W'(z);
        req.sphere_size   = spce_pkg::RAD_W'(rad);
        req.owner_link    = spce_pkg::LINK_W'(link);
        loaded[idx] = 1'b1;
        recent_loads = {recent_loads, idx};
        if (recent_loads.size() > 8)
            void'(recent_loads.pop_front());
        send_request(req);
    endtask

    task automatic check_pair(int a, int b);
        spce_pkg::request_t req;
        logic [127:0]       noise;
        noise             = {$urandom, $urandom, $urandom, $urandom};
        req               = noise[$bits(spce_pkg::request_t)-1:0];
        req.action        = spce_pkg::ACT_CHECK;
        req.first_sphere  = spce_pkg::IDX_W'(a);
        req.second_sphere = spce_pkg::IDX_W'(b);
        send_request(req);
    endtask

    task automatic wait_until_drained();
        request_valid <= 1'b0;
        while (pending_contacts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        load_sphere(0, 0, 0, 0, 1000, 1);
        load_sphere(1, 2000, 0, 0, 1000, 2);
        load_sphere(2, 2001, 0, 0, 1000, 3);
        load_sphere(3, 100, 100, 100, 0, 255);
        load_sphere(4, 100, 100, 100, 0, 0);
        load_sphere(5, 8388607, 8388607, 8388607, 1048575, 170);
        load_sphere(6, -8388608, -8388608, -8388608, 1048575, 85);
        load_sphere(7, 0, 0, -300, 1048575, 7);
        load_sphere(8, 3, -4, 12, 20, 8);
        check_pair(0, 1);
        check_pair(0, 2);
        check_pair(1, 0);
        check_pair(0, 0);
        check_pair(3, 4);
        check_pair(5, 6);
        check_pair(5, 5);
        check_pair(0, 7);
        check_pair(7, 0);
        check_pair(8, 0);
        check_pair(0, 8);
    endtask

    task automatic test_pause_until_drained();
        load_sphere(9, 500, 500, 500, 700, 9);
        check_pair(9, 0);
        wait_until_drained();
        check_pair(0, 9);
    endtask

    task automatic test_random_traffic(int count);
        int a, b, scale, pick;
        for (int i = 0; i < count; i++)
        begin
            if (i == count - 150)
                idle_enable = 1'b0;
            if ($urandom_range(0, 30) == 0)
            begin
                cluster_x = spce_pkg::COORD_W'($urandom_range(0, 8388607) - 4194304);
                cluster_y = spce_pkg::COORD_W'($urandom_range(0, 8388607) - 4194304);
                cluster_z = spce_pkg::COORD_W'($urandom_range(0, 8388607) - 4194304);
            end
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                a = $urandom_range(0, SPHERES - 1);
                if ($urandom_range(0, 9) == 0)
                    load_sphere(a, $urandom, $urandom, $urandom, $urandom, $urandom);
                else
                begin
                    scale = 1 << $urandom_range(0, 20);
                    load_sphere(a,
                        cluster_x + int'($urandom_range(0, 2 * scale)) - scale,
                        cluster_y + int'($urandom_range(0, 2 * scale)) - scale,
                        cluster_z + int'($urandom_range(0, 2 * scale)) - scale,
                        $urandom_range(0, scale), $urandom_range(0, 255));
                end
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    a = recent_loads[$urandom_range(0, recent_loads.size() - 1)];
                    b = recent_loads[$urandom_range(0, recent_loads.size() - 1)];
                end
                else
                begin
                    do
                        a = $urandom_range(0, SPHERES - 1);
                    while (!loaded[a]);
                    do
                        b = $urandom_range(0, SPHERES - 1);
                    while (!loaded[b]);
                end
                check_pair(a, b);
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        request_valid = 1'b0;
        request       = '0;
        idle_enable   = 1'b1;
        cluster_x     = '0;
        cluster_y     = '0;
        cluster_z     = '0;
        for (int i = 0; i < SPHERES; i++)
            loaded[i] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_pause_until_drained();
        test_random_traffic(1000);
        request_valid <= 1'b0;
        while (pending_contacts.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* sphere_pair_contact_engine.f */
rtl/spce_pkg.sv
rtl/spce_table.sv
rtl/spce_sqrt.sv
rtl/spce_div.sv
rtl/sphere_pair_contact_engine.sv
sim/sphere_pair_contact_engine_tb.sv
